### sv/cbh_pkg.sv
package cbh_pkg;

   localparam int MAX_CELLS  = 4;
   localparam int CELL_MV_W  = 16;
   localparam int ACTION_W   = 2;
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 16;

   // request word layout: charging_cv, then cell_mv_0 .. cell_mv_3
   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 8;

   localparam logic [ACTION_W-1:0] ACT_UPDATE    = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_TOGGLE_OV = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_CLEAR_OV  = 2'd2;

   localparam logic [CSR_ADDR_W-1:0] REG_START_TH = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_STOP_TH  = 1'd1;

   localparam logic [CELL_MV_W-1:0] START_TH_RESET = 16'd30;
   localparam logic [CELL_MV_W-1:0] STOP_TH_RESET  = 16'd20;

   typedef logic [CELL_MV_W-1:0] mv_type;
   typedef mv_type [MAX_CELLS-1:0] cell_vec_type;
   typedef logic [MAX_CELLS-1:0] mask_type;

   // one word after the minimum search stage
   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic                charging_cv;
      cell_vec_type        cells;
      mv_type              low_mv;
   } stage_type;

   // per-lane threshold results, before the hysteresis select
   typedef struct packed {
      logic ge_start;
      logic ge_stop;
   } lane_cmp_type;

endpackage

### sv/cbh_min.sv
module cbh_min #(
   parameter int CELL_COUNT = 4
) (
   input  cbh_pkg::cell_vec_type cells,
   output cbh_pkg::mv_type       low_mv
);

   // small compare chain over at most four cells
   always_comb begin
      low_mv = cells[0];
      for (int i = 1; i < CELL_COUNT; i++) begin
         if (cells[i] < low_mv) begin
            low_mv = cells[i];
         end
      end
   end

endmodule

### sv/cbh_lane.sv
module cbh_lane (
   input  cbh_pkg::mv_type       cell_mv,
   input  cbh_pkg::mv_type       low_mv,
   input  cbh_pkg::mv_type       start_th,
   input  cbh_pkg::mv_type       stop_th,
   output cbh_pkg::lane_cmp_type cmp
);

   cbh_pkg::mv_type excess;

   // low_mv never exceeds cell_mv, so the difference cannot wrap
   assign excess      = cell_mv - low_mv;
   assign cmp.ge_start = (excess >= start_th);
   assign cmp.ge_stop  = (excess >= stop_th);

endmodule

### sv/cell_balance_hysteresis_mask.sv
// Passive cell-balancing mask with per-cell hysteresis. Each request word is an action:
// an update carries CELL_COUNT cell voltages (mV) and the constant-voltage charge flag;
// while that flag or the manual override is set, the lowest cell is found and each cell
// starts bleeding once its excess over that minimum reaches the start threshold, and keeps
// bleeding while the excess stays at or above the stop threshold; otherwise the mask is
// cleared. The toggle and clear actions act on the override only, and action code 3 does
// nothing. Every request produces exactly one response word carrying the mask, a pulse set
// when an update changed the mask (a full-replace write to the bleed driver is due), and
// the override flag. The minimum search is registered in the first stage, the per-cell
// lanes and the mask merge in the response register behind it. Throughput is one word
// per cycle while the response is not stalled, set by the mask/override feedback in the merge
// stage; a stalled response holds in its register while the minimum stage can still take one
// more word. Thresholds are to be written on the csr port while no word is in flight; the block does not enforce it.
module cell_balance_hysteresis_mask #(
   parameter int CELL_COUNT = 4
) (
   input  logic                                       clock,
   input  logic                                       reset,
   // csr write port: register 0 start threshold, register 1 stop threshold
   input  logic                                       csr_we,
   input  logic [cbh_pkg::CSR_ADDR_W-1:0]             csr_addr,
   input  logic [cbh_pkg::CSR_DATA_W-1:0]             csr_wdata,
   // request channel
   input  logic                                       req_tvalid,
   output logic                                       req_tready,
   // tdata: charging_cv[0], cell_mv_0[16:1], cell_mv_1[32:17],
   //        cell_mv_2[48:33], cell_mv_3[64:49], zero pad[71:65]
   input  logic [cbh_pkg::REQ_DATA_W-1:0]             req_tdata,
   // tuser: action[1:0]
   input  logic [cbh_pkg::ACTION_W-1:0]               req_tuser,
   // response channel
   output logic                                       rsp_tvalid,
   input  logic                                       rsp_tready,
   // tdata: balance_mask[3:0], mask_written[4], override_on[5], zero pad[7:6]
   output logic [cbh_pkg::RSP_DATA_W-1:0]             rsp_tdata
);

   // threshold registers
   cbh_pkg::mv_type start_th_ff, start_th_in;
   cbh_pkg::mv_type stop_th_ff,  stop_th_in;

   // minimum search stage
   logic               s1_valid_ff, s1_valid_in;
   cbh_pkg::stage_type s1_ff, s1_in;
   cbh_pkg::cell_vec_type req_cells;
   cbh_pkg::mv_type       req_low_mv;

   // merge stage state, which doubles as the response register
   cbh_pkg::mask_type mask_ff, mask_in;
   logic              ovr_ff, ovr_in;
   logic              written_ff, written_in;
   logic              rsp_valid_ff, rsp_valid_in;

   cbh_pkg::lane_cmp_type [cbh_pkg::MAX_CELLS-1:0] lane_cmp;
   cbh_pkg::mask_type lane_hit;
   cbh_pkg::mask_type target;
   logic              rsp_free;

   // csr writes
   always_comb begin
      start_th_in = start_th_ff;
      stop_th_in  = stop_th_ff;
      if (csr_we) begin
         case (csr_addr)
            cbh_pkg::REG_START_TH: start_th_in = csr_wdata;
            cbh_pkg::REG_STOP_TH:  stop_th_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   // unpack the request word
   always_comb begin
      for (int i = 0; i < cbh_pkg::MAX_CELLS; i++) begin
         req_cells[i] = req_tdata[1 + i*cbh_pkg::CELL_MV_W +: cbh_pkg::CELL_MV_W];
      end
   end

   cbh_min #(.CELL_COUNT(CELL_COUNT)) u_min (
      .cells  (req_cells),
      .low_mv (req_low_mv)
   );

   // handshake: the response register frees when empty or being taken,
   // the first stage frees when empty or moving on
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || rsp_free;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_in       = s1_ff;
      if (req_tready) begin
         s1_valid_in       = req_tvalid;
         s1_in.action      = req_tuser;
         s1_in.charging_cv = req_tdata[0];
         s1_in.cells       = req_cells;
         s1_in.low_mv      = req_low_mv;
      end
   end

   // per-cell lanes; cells beyond CELL_COUNT never bleed
   for (genvar g = 0; g < cbh_pkg::MAX_CELLS; g++) begin : g_lane
      if (g < CELL_COUNT) begin : g_on
         cbh_lane u_lane (
            .cell_mv  (s1_ff.cells[g]),
            .low_mv   (s1_ff.low_mv),
            .start_th (start_th_ff),
            .stop_th  (stop_th_ff),
            .cmp      (lane_cmp[g])
         );
         // hysteresis: a balancing cell is held to the lower stop threshold
         assign lane_hit[g] = mask_ff[g] ? lane_cmp[g].ge_stop : lane_cmp[g].ge_start;
      end else begin : g_off
         assign lane_cmp[g] = '0;
         assign lane_hit[g] = lane_cmp[g].ge_start;
      end
   end

   // merge: balancing is only enabled in cv charge or under override
   assign target = (s1_ff.charging_cv || ovr_ff) ? lane_hit : '0;

   always_comb begin
      mask_in      = mask_ff;
      ovr_in       = ovr_ff;
      written_in   = written_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_free) begin
         rsp_valid_in = s1_valid_ff;
         if (s1_valid_ff) begin
            written_in = 1'b0;
            case (s1_ff.action)
               cbh_pkg::ACT_UPDATE: begin
                  mask_in    = target;
                  written_in = (target != mask_ff);
               end
               cbh_pkg::ACT_TOGGLE_OV: ovr_in = !ovr_ff;
               cbh_pkg::ACT_CLEAR_OV:  ovr_in = 1'b0;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_th_ff  <= cbh_pkg::START_TH_RESET;
         stop_th_ff   <= cbh_pkg::STOP_TH_RESET;
         s1_valid_ff  <= 1'b0;
         mask_ff      <= '0;
         ovr_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         written_ff   <= 1'b0;
      end else begin
         start_th_ff  <= start_th_in;
         stop_th_ff   <= stop_th_in;
         s1_valid_ff  <= s1_valid_in;
         mask_ff      <= mask_in;
         ovr_ff       <= ovr_in;
         rsp_valid_ff <= rsp_valid_in;
         written_ff   <= written_in;
      end
   end

   // payload stage needs no reset
   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, ovr_ff, written_ff, mask_ff};

endmodule

### sv/cbh_checker.sv
module cbh_checker #(
   parameter int CELL_COUNT = 4
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [cbh_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   localparam logic [cbh_pkg::MAX_CELLS-1:0] USED_MASK =
      cbh_pkg::MAX_CELLS'((1 << CELL_COUNT) - 1);

   // mask of the last delivered response word
   logic [cbh_pkg::MAX_CELLS-1:0] last_mask_ff, last_mask_in;

   assign last_mask_in = (rsp_tvalid && rsp_tready) ? rsp_tdata[3:0] : last_mask_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_mask_ff <= '0;
      end else begin
         last_mask_ff <= last_mask_in;
      end
   end

   // a stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response word changed while stalled");

   // the written pulse marks exactly the words whose mask differs from the last one
   a_written_match: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[4] == (rsp_tdata[3:0] != last_mask_ff)))
      else $error("mask_written does not match mask change");

   // cells beyond the configured count never bleed, pad bits stay zero
   a_unused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata[3:0] & ~USED_MASK) == '0) && (rsp_tdata[7:6] == 2'b00))
      else $error("unused mask or pad bits set");

   // a response needs an earlier request: none right out of reset
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid right after reset");

   // after an accepted request word, the response register is checked to be valid once the
   // word has passed the minimum stage; an older word still waiting there also counts
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> ##1 rsp_tvalid)
      else $error("accepted request word never reached the response register");

endmodule

bind cell_balance_hysteresis_mask cbh_checker #(.CELL_COUNT(CELL_COUNT)) u_cbh_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
